[sv/base64_stream_codec_top_assert.svh]
// Assertion macros for the Base64 stream codec.
// Used by base64_stream_codec_top; no other dependencies.
`ifndef BASE64_STREAM_CODEC_TOP_ASSERT_SVH
`define BASE64_STREAM_CODEC_TOP_ASSERT_SVH
`ifndef ASSERT_OFF
`define B64SC_ASSERT(lbl, clk_s, rstn_s, prop) \
	lbl: assert property (@(posedge clk_s) disable iff (!rstn_s) prop) \
		else $error("b64sc assertion failed");
`define B64SC_NEVER(lbl, clk_s, rstn_s, expr) \
	lbl: assert property (@(posedge clk_s) disable iff (!rstn_s) !(expr)) \
		else $error("b64sc forbidden condition");
`else
`define B64SC_ASSERT(lbl, clk_s, rstn_s, prop)
`define B64SC_NEVER(lbl, clk_s, rstn_s, expr)
`endif
`endif

[sv/b64sc_pkg.sv]
// Types, codes and alphabet functions for the Base64 stream codec.
// No dependencies; imported by every module of the block.
package b64sc_pkg;

	typedef struct packed {
		logic [7:0] in_byte;
		logic       in_last;
	} in_item_t;

	typedef struct packed {
		logic [7:0] out_byte;
		logic       out_last;
		logic       out_error;
	} out_item_t;

	localparam logic [1:0] KIND_ENC = 2'd0;
	localparam logic [1:0] KIND_DEC = 2'd1;
	localparam logic [1:0] KIND_ERR = 2'd2;

	// one finished group: encode cnt = bytes held (1..3), decode cnt = bytes out (1..3)
	typedef struct packed {
		logic [1:0]  kind;
		logic [23:0] bits;
		logic [1:0]  cnt;
		logic        last;
	} grp_t;

	localparam logic [7:0] PAD_CHAR   = 8'h3D;
	localparam logic [7:0] PLUS_CHAR  = 8'h2B;
	localparam logic [7:0] SLASH_CHAR = 8'h2F;

	function automatic logic [7:0] sextet_char(input logic [5:0] v);
		logic [7:0] w;
		w = {2'b00, v};
		if (v < 6'd26) return 8'h41 + w;
		if (v < 6'd52) return 8'h61 + w - 8'd26;
		if (v < 6'd62) return 8'h30 + w - 8'd52;
		return (v == 6'd62) ? PLUS_CHAR : SLASH_CHAR;
	endfunction

	// {valid, sextet}
	function automatic logic [6:0] char_sextet(input logic [7:0] c);
		logic [7:0] d;
		d = 8'd0;
		if (c >= 8'h41 && c <= 8'h5A) begin
			d = c - 8'h41;
			return {1'b1, d[5:0]};
		end
		if (c >= 8'h61 && c <= 8'h7A) begin
			d = c - 8'h61 + 8'd26;
			return {1'b1, d[5:0]};
		end
		if (c >= 8'h30 && c <= 8'h39) begin
			d = c - 8'h30 + 8'd52;
			return {1'b1, d[5:0]};
		end
		if (c == PLUS_CHAR) return {1'b1, 6'd62};
		if (c == SLASH_CHAR) return {1'b1, 6'd63};
		return 7'd0;
	endfunction

endpackage

[sv/b64sc_fifo.sv]
// Short group queue between the front and back of the Base64 codec.
// Depends on b64sc_pkg for the group entry type.
module b64sc_fifo import b64sc_pkg::*; #(
	parameter int DEPTH = 2
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       push,
	input  grp_t                       push_data,
	input  logic                       pop,
	output grp_t                       head,
	output logic                       full,
	output logic                       empty,
	output logic [$clog2(DEPTH+1)-1:0] count
);

	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);

	grp_t          mem_q [DEPTH];
	logic [AW-1:0] wr_ptr_q;
	logic [AW-1:0] rd_ptr_q;
	logic [CW-1:0] cnt_q;

	assign head  = mem_q[rd_ptr_q];
	assign full  = (cnt_q == CW'(DEPTH));
	assign empty = (cnt_q == '0);
	assign count = cnt_q;

	always_ff @(posedge clk) begin
		if (push) mem_q[wr_ptr_q] <= push_data;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (push) wr_ptr_q <= (wr_ptr_q == AW'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			if (pop) rd_ptr_q <= (rd_ptr_q == AW'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			if (push && !pop) cnt_q <= cnt_q + 1'b1;
			else if (pop && !push) cnt_q <= cnt_q - 1'b1;
		end
	end

endmodule

[sv/b64sc_front.sv]
// Front of the Base64 codec: accepts items, gathers groups, checks decode input.
// Depends on b64sc_pkg; pushes finished groups into b64sc_fifo.
module b64sc_front import b64sc_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     cfg_we,
	input  logic     cfg_data,
	input  logic     in_valid,
	output logic     in_ready,
	input  in_item_t in_item,
	input  logic     q_full,
	output logic     q_push,
	output grp_t     q_entry
);

	logic        mode_q;
	logic [23:0] bits_q;
	logic [1:0]  count_q;
	logic        twp_q;
	logic        drop_q;

	logic        acc;
	logic [6:0]  cs;
	logic        is_pad;
	logic        err;
	logic [23:0] nbits;
	logic        done;

	assign in_ready = !q_full;
	assign acc      = in_valid && in_ready;
	assign cs       = char_sextet(in_item.in_byte);
	assign is_pad   = (in_item.in_byte == PAD_CHAR);

	always_comb begin
		err = 1'b0;
		if (!cs[6] && !is_pad) err = 1'b1;
		else if (is_pad) begin
			if (count_q < 2'd2) err = 1'b1;
			else if (count_q == 2'd2) err = in_item.in_last;
			else err = !in_item.in_last;
		end else if (twp_q) err = 1'b1;
		if (in_item.in_last && count_q != 2'd3) err = 1'b1;
	end

	always_comb begin
		nbits = bits_q;
		if (mode_q) begin
			case (count_q)
				2'd0: nbits[23:18] = cs[5:0];
				2'd1: nbits[17:12] = cs[5:0];
				2'd2: nbits[11:6]  = cs[5:0];
				default: nbits[5:0] = cs[5:0];
			endcase
		end else begin
			case (count_q)
				2'd0: nbits[23:16] = in_item.in_byte;
				2'd1: nbits[15:8]  = in_item.in_byte;
				default: nbits[7:0] = in_item.in_byte;
			endcase
		end
	end

	always_comb begin
		q_entry      = '0;
		q_entry.bits = nbits;
		q_entry.last = in_item.in_last;
		done         = 1'b0;
		if (mode_q) begin
			if (err) begin
				q_entry.kind = KIND_ERR;
				done         = 1'b1;
			end else if (count_q == 2'd3) begin
				q_entry.kind = KIND_DEC;
				q_entry.cnt  = twp_q ? 2'd1 : (is_pad ? 2'd2 : 2'd3);
				done         = 1'b1;
			end
		end else begin
			q_entry.kind = KIND_ENC;
			q_entry.cnt  = count_q + 2'd1;
			done         = (count_q == 2'd2) || in_item.in_last;
		end
	end

	assign q_push = acc && !drop_q && done;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q  <= 1'b0;
			bits_q  <= '0;
			count_q <= '0;
			twp_q   <= 1'b0;
			drop_q  <= 1'b0;
		end else if (cfg_we) begin
			mode_q  <= cfg_data;
			bits_q  <= '0;
			count_q <= '0;
			twp_q   <= 1'b0;
			drop_q  <= 1'b0;
		end else if (acc) begin
			if (drop_q) begin
				if (in_item.in_last) drop_q <= 1'b0;
			end else if (done) begin
				bits_q  <= '0;
				count_q <= '0;
				twp_q   <= 1'b0;
				drop_q  <= mode_q && err && !in_item.in_last;
			end else begin
				bits_q  <= nbits;
				count_q <= count_q + 2'd1;
				if (mode_q && is_pad) twp_q <= 1'b1;
			end
		end
	end

endmodule

[sv/b64sc_back.sv]
// Back of the Base64 codec: expands queued groups into output items.
// Depends on b64sc_pkg; reads the head of b64sc_fifo.
module b64sc_back import b64sc_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      q_empty,
	input  grp_t      q_head,
	output logic      q_pop,
	output logic      out_valid,
	input  logic      out_ready,
	output out_item_t out_item
);

	logic [1:0] idx_q;
	logic       out_valid_q;
	out_item_t  out_q;

	logic       load;
	logic       final_item;
	out_item_t  item;
	logic [5:0] sx;

	assign load      = !q_empty && (!out_valid_q || out_ready);
	assign q_pop     = load && final_item;
	assign out_valid = out_valid_q;
	assign out_item  = out_q;

	always_comb begin
		case (idx_q)
			2'd0: sx = q_head.bits[23:18];
			2'd1: sx = q_head.bits[17:12];
			2'd2: sx = q_head.bits[11:6];
			default: sx = q_head.bits[5:0];
		endcase
	end

	always_comb begin
		item       = '0;
		final_item = 1'b1;
		unique case (q_head.kind)
			KIND_ENC: begin
				item.out_byte = (idx_q <= q_head.cnt) ? sextet_char(sx) : PAD_CHAR;
				final_item    = (idx_q == 2'd3);
				item.out_last = final_item && q_head.last;
			end
			KIND_DEC: begin
				case (idx_q)
					2'd0: item.out_byte = q_head.bits[23:16];
					2'd1: item.out_byte = q_head.bits[15:8];
					default: item.out_byte = q_head.bits[7:0];
				endcase
				final_item    = (idx_q == q_head.cnt - 2'd1);
				item.out_last = final_item && q_head.last;
			end
			default: begin
				item.out_last  = 1'b1;
				item.out_error = 1'b1;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (load) out_q <= item;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q       <= '0;
			out_valid_q <= 1'b0;
		end else if (load) begin
			out_valid_q <= 1'b1;
			idx_q       <= final_item ? 2'd0 : idx_q + 2'd1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

endmodule

[sv/base64_stream_codec_top.sv]
// Base64 stream codec, standard alphabet with '=' padding.
// Input channel: in_valid/in_ready carry one byte or character plus an end mark.
// Output channel: out_valid/out_ready carry one character or byte, last and error.
// cfg_we/cfg_data set the direction (1 = decode) and restart the message.
// The front takes one item per cycle while the group queue has room; the back
// sends one result per cycle from its output register while out_ready is high.
// The item that completes a group is written into the group queue and then its first
// result is loaded into the output register; the rest follow one per cycle while out_ready is high.
// Encode gives four output characters for every three input bytes, so a steady
// encode stream is limited by the output port (one result per cycle); decode
// runs at one character per cycle while out_ready is high.
// A malformed decode message gives one result with out_error and out_last set,
// then input is taken and dropped until its end mark.
// Reset clears the queue, the group state and selects encode.
// When out_ready is low the output holds; the queue fills and then in_ready drops.
`include "base64_stream_codec_top_assert.svh"
module base64_stream_codec_top import b64sc_pkg::*; #(
	parameter int QUEUE_DEPTH = 2
) (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      cfg_we,
	input  logic      cfg_data,
	input  logic      in_valid,
	output logic      in_ready,
	input  in_item_t  in_item,
	output logic      out_valid,
	input  logic      out_ready,
	output out_item_t out_item
);

	grp_t                             q_entry;
	grp_t                             q_head;
	logic                             q_push;
	logic                             q_pop;
	logic                             q_full;
	logic                             q_empty;
	logic [$clog2(QUEUE_DEPTH+1)-1:0] q_count;

	b64sc_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_we   (cfg_we),
		.cfg_data (cfg_data),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.in_item  (in_item),
		.q_full   (q_full),
		.q_push   (q_push),
		.q_entry  (q_entry)
	);

	b64sc_fifo #(
		.DEPTH (QUEUE_DEPTH)
	) u_fifo (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (q_push),
		.push_data (q_entry),
		.pop       (q_pop),
		.head      (q_head),
		.full      (q_full),
		.empty     (q_empty),
		.count     (q_count)
	);

	b64sc_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.q_empty   (q_empty),
		.q_head    (q_head),
		.q_pop     (q_pop),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_item  (out_item)
	);

	`B64SC_ASSERT(a_err_is_last, clk, arst_n, out_valid && out_item.out_error |-> out_item.out_last && out_item.out_byte == 8'd0)
	`B64SC_ASSERT(a_q_bound, clk, arst_n, q_count <= ($clog2(QUEUE_DEPTH+1))'(QUEUE_DEPTH))
	`B64SC_NEVER(a_no_push_full, clk, arst_n, q_push && q_full)
	`B64SC_NEVER(a_no_pop_empty, clk, arst_n, q_pop && q_empty)

endmodule

[bench/testbench.sv]
// Self-checking bench for base64_stream_codec_top: encode and decode phases
// with bursty input, output stalls and a built-in codec predictor.
// Depends on b64sc_pkg for the item types and the pad character.
module testbench;
	import b64sc_pkg::*;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int WATCHDOG_LIMIT = 3000;
	localparam int RANDOM_ITEMS   = 280;
	localparam int PHASE_ITEMS    = 35;

	logic      clk;
	logic      arst_n;
	logic      cfg_we;
	logic      cfg_data;
	logic      in_valid;
	logic      in_ready;
	in_item_t  in_item;
	logic      out_valid;
	logic      out_ready;
	out_item_t out_item;

	base64_stream_codec_top i_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_we   (cfg_we),
		.cfg_data (cfg_data),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.in_item  (in_item),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.out_item (out_item)
	);

	in_item_t  pending_in[$];
	out_item_t expected_out[$];

	// predictor state
	bit          cur_decode;
	logic [23:0] grp_bits;
	int          grp_cnt;
	bit          pad_in_third;
	bit          skip_to_end;

	int fail_count;
	int idle_cycles;
	int burst_left;
	int gap_left;
	int stall_cycles;
	logic [15:0] stall_pat;

	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	function automatic logic [7:0] b64_letter(input logic [5:0] v);
		logic [7:0] w;
		w = {2'b00, v};
		if (v < 6'd26) return 8'h41 + w;
		if (v < 6'd52) return 8'h61 + w - 8'd26;
		if (v < 6'd62) return 8'h30 + w - 8'd52;
		return (v == 6'd62) ? 8'h2B : 8'h2F;
	endfunction

	function automatic bit b64_value(input logic [7:0] c, output logic [5:0] v);
		v = 6'd0;
		if (c >= 8'h41 && c <= 8'h5A) v = 6'(c - 8'h41);
		else if (c >= 8'h61 && c <= 8'h7A) v = 6'(c - 8'h61 + 26);
		else if (c >= 8'h30 && c <= 8'h39) v = 6'(c - 8'h30 + 52);
		else if (c == 8'h2B) v = 6'd62;
		else if (c == 8'h2F) v = 6'd63;
		else return 1'b0;
		return 1'b1;
	endfunction

	task automatic drop_group();
		grp_bits = '0;
		grp_cnt = 0;
		pad_in_third = 1'b0;
	endtask

	task automatic add_result(input logic [7:0] b, input logic last, input logic err);
		out_item_t r;
		r.out_byte = b;
		r.out_last = last;
		r.out_error = err;
		expected_out.push_back(r);
	endtask

	task automatic codec_predict(input in_item_t it);
		logic [5:0] v;
		bit ok;
		bit pad;
		bit err;
		int p;
		int n;
		if (skip_to_end) begin
			if (it.in_last) skip_to_end = 1'b0;
			return;
		end
		p = grp_cnt;
		if (cur_decode) begin
			ok = b64_value(it.in_byte, v);
			pad = (it.in_byte == PAD_CHAR);
			err = 1'b0;
			if (!ok && !pad) err = 1'b1;
			else if (pad) begin
				if (p < 2) err = 1'b1;
				else if (p == 2) err = it.in_last;
				else err = !it.in_last;
			end else if (pad_in_third) err = 1'b1;
			if (it.in_last && p != 3) err = 1'b1;
			if (err) begin
				add_result(8'h00, 1'b1, 1'b1);
				drop_group();
				skip_to_end = !it.in_last;
				return;
			end
			grp_bits = grp_bits | (24'(v) << (18 - 6 * p));
			if (p < 3) begin
				if (pad) pad_in_third = 1'b1;
				grp_cnt = p + 1;
				return;
			end
			n = pad_in_third ? 1 : (pad ? 2 : 3);
			for (int k = 0; k < n; k++)
				add_result(8'(grp_bits >> (16 - 8 * k)), (k == n - 1) ? it.in_last : 1'b0, 1'b0);
			drop_group();
		end else begin
			if (p > 2) begin
				drop_group();
				p = 0;
			end
			grp_bits = grp_bits | (24'(it.in_byte) << (16 - 8 * p));
			p++;
			if (p < 3 && !it.in_last) begin
				grp_cnt = p;
				return;
			end
			for (int i = 0; i < 4; i++)
				add_result((i <= p) ? b64_letter(6'(grp_bits >> (18 - 6 * i))) : PAD_CHAR,
					(i == 3) ? it.in_last : 1'b0, 1'b0);
			drop_group();
		end
	endtask

	task automatic push_item(input logic [7:0] b, input logic last);
		in_item_t it;
		it.in_byte = b;
		it.in_last = last;
		pending_in.push_back(it);
	endtask

	task automatic queue_text(input string s);
		for (int i = 0; i < s.len(); i++)
			push_item(s[i], i == s.len() - 1);
	endtask

	task automatic wait_drained();
		@(negedge clk);
		while (pending_in.size() != 0 || in_valid || expected_out.size() != 0)
			@(negedge clk);
	endtask

	// register writes only with the codec idle; a write restarts the message
	task automatic set_direction(input bit dec);
		wait_drained();
		repeat (8) @(posedge clk);
		cfg_we <= 1'b1;
		cfg_data <= dec;
		@(posedge clk);
		cfg_we <= 1'b0;
		cur_decode = dec;
		skip_to_end = 1'b0;
		drop_group();
		@(negedge clk);
	endtask

	initial begin
		int total_items;
		int phase_items;
		int phase;
		int len;
		int pos;
		bit mode;
		logic [7:0] text[$];
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_data = 1'b0;
		in_valid = 1'b0;
		in_item = '0;
		out_ready = 1'b0;
		fail_count = 0;
		cur_decode = 1'b0;
		skip_to_end = 1'b0;
		drop_group();
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;

		set_direction(1'b0);
		push_item(8'h00, 1'b1);
		push_item(8'hFF, 1'b0);
		push_item(8'hFF, 1'b1);
		push_item(8'h00, 1'b0);
		push_item(8'hFF, 1'b0);
		push_item(8'h80, 1'b1);

		set_direction(1'b1);
		queue_text("+/==");
		queue_text("Za9=");
		queue_text("=A");      // pad first
		queue_text("AB=C");    // data after third-position pad
		queue_text("ABC=A");   // pad in a group that is not final
		queue_text("AB");      // short final group
		push_item(8'h80, 1'b1);

		mode = 1'b1;
		phase = 0;
		total_items = 0;
		while (total_items < RANDOM_ITEMS) begin
			if (phase % 3 != 2) mode = !mode;
			set_direction(mode);
			phase_items = 0;
			while (phase_items < PHASE_ITEMS) begin
				text.delete();
				if (!mode) begin
					len = ($urandom_range(0, 5) == 0) ? $urandom_range(9, 20) : $urandom_range(1, 8);
					repeat (len) text.push_back(8'($urandom_range(0, 255)));
				end else begin
					repeat (4 * $urandom_range(1, 3)) text.push_back(b64_letter(6'($urandom)));
					len = text.size();
					case ($urandom_range(0, 2))
						1: text[len - 1] = PAD_CHAR;
						2: begin
							text[len - 1] = PAD_CHAR;
							text[len - 2] = PAD_CHAR;
						end
						default: ;
					endcase
					if ($urandom_range(0, 3) == 0) begin
						pos = $urandom_range(0, len - 1);
						case ($urandom_range(0, 3))
							0: text[pos] = 8'($urandom_range(0, 255));
							1: text[pos] = PAD_CHAR;
							2: while (text.size() > pos + 1) text.delete(text.size() - 1);
							default: text.push_back(b64_letter(6'($urandom)));
						endcase
					end
				end
				foreach (text[i]) push_item(text[i], i == text.size() - 1);
				phase_items += text.size();
			end
			// sometimes leave a message open across the register write
			if ($urandom_range(0, 1) == 1) begin
				push_item(8'($urandom_range(0, 255)), 1'b0);
				phase_items++;
			end
			total_items += phase_items;
			phase++;
		end

		wait_drained();
		repeat (20) @(posedge clk);
		if (fail_count == 0 && expected_out.size() == 0) begin
			$display("testbench: clean");
		end else begin
			$display("testbench: errors");
		end
		$finish;
	end

	always @(posedge clk) begin
		if (!arst_n) begin
			in_valid <= 1'b0;
			burst_left = 0;
			gap_left = 0;
		end else begin
			if (in_valid && in_ready)
				codec_predict(in_item);
			if (!in_valid || in_ready) begin
				if (gap_left > 0) begin
					gap_left--;
					in_valid <= 1'b0;
				end else if (pending_in.size() != 0) begin
					in_item <= pending_in.pop_front();
					in_valid <= 1'b1;
					if (burst_left > 1) begin
						burst_left--;
					end else begin
						burst_left = $urandom_range(1, 24);
						gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 7);
					end
				end else begin
					in_valid <= 1'b0;
				end
			end
		end
	end

	always @(posedge clk) begin
		if (!arst_n) begin
			stall_cycles = 0;
			stall_pat = 16'hFFFF;
			out_ready <= 1'b0;
		end else begin
			if (stall_cycles == 0) begin
				stall_cycles = $urandom_range(16, 96);
				case ($urandom_range(0, 3))
					0: stall_pat = 16'hFFFF;
					1: stall_pat = 16'($urandom) | 16'h0001;
					2: stall_pat = 16'h0001;
					default: stall_pat = 16'hF0F0;
				endcase
			end else begin
				stall_cycles--;
				stall_pat = {stall_pat[0], stall_pat[15:1]};
			end
			out_ready <= stall_pat[0];
		end
	end

	always @(posedge clk) begin
		out_item_t want;
		if (arst_n && out_valid && out_ready) begin
			if (expected_out.size() == 0) begin
				fail_count++;
				if (fail_count <= 10)
					$display("unexpected item: byte=%h last=%b error=%b",
						out_item.out_byte, out_item.out_last, out_item.out_error);
			end else begin
				want = expected_out.pop_front();
				if (out_item.out_byte !== want.out_byte || out_item.out_last !== want.out_last ||
						out_item.out_error !== want.out_error) begin
					fail_count++;
					if (fail_count <= 10)
						$display("mismatch: want byte=%h last=%b error=%b, got byte=%h last=%b error=%b",
							want.out_byte, want.out_last, want.out_error,
							out_item.out_byte, out_item.out_last, out_item.out_error);
				end
			end
		end
	end

	always @(posedge clk) begin
		if (!arst_n || (in_valid && in_ready) || (out_valid && out_ready)) begin
			idle_cycles <= 0;
		end else if (idle_cycles >= WATCHDOG_LIMIT) begin
			$display("testbench: errors");
			$finish;
		end else begin
			idle_cycles <= idle_cycles + 1;
		end
	end

endmodule

[sim.f]
+incdir+sv
sv/b64sc_pkg.sv
sv/b64sc_fifo.sv
sv/b64sc_front.sv
sv/b64sc_back.sv
sv/base64_stream_codec_top.sv
bench/testbench.sv
